@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define VRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define VRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/vrf_pkg.sv @@
// Shared types and constants of the visible range finder.
// No dependencies; used by vrf_ctrl, vrf_dp and visible_range_finder.
`default_nettype none

package vrf_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 2'd3;

	// request kinds
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic MODE_FIXED = 1'b0;

	// prefix table read selects
	localparam logic [2:0] RD_IDX   = 3'd0;
	localparam logic [2:0] RD_MID   = 3'd1;
	localparam logic [2:0] RD_START = 3'd2;
	localparam logic [2:0] RD_COUNT = 3'd3;
	localparam logic [2:0] RD_END   = 3'd4;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic       latch;
		logic [2:0] rd_sel;
		logic       ld_write;
		logic       div_init;
		logic       div_step;
		logic       fx_start;
		logic       fx_mul;
		logic       bs_init;
		logic       bs_update;
		logic       set_start;
		logic       cap_offset;
		logic       cap_total;
		logic       scan_update;
		logic       finish;
		logic       clear_res;
		logic       publish;
	} vrf_cmd_t;

	typedef struct packed {
		logic action;
		logic size_mode;
		logic empty;
		logic div_last;
		logic bs_more;
		logic scan_more;
		logic scan_hit;
		logic out_busy;
	} vrf_stat_t;

endpackage

`default_nettype wire

@@ hdl/vrf_dp.sv @@
// Datapath: configuration registers, prefix table memory, dual restoring
// divider, search and scan registers, result register. Depends on vrf_pkg.
`default_nettype none

module vrf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vrf_pkg::vrf_cmd_t                 cmd,
	output vrf_pkg::vrf_stat_t                stat,
	input  logic [vrf_pkg::IN_DATA_W-1:0]     in_data,
	input  logic                              in_user,
	input  logic                              cfg_we,
	input  logic [vrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vrf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vrf_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int IW = vrf_pkg::IDX_W;
	localparam int CW = vrf_pkg::CNT_W;
	localparam logic [CW+1:0] MARGIN_FIXED = (CW+2)'(2);

	function automatic logic [31:0] sat32(input logic [34:0] v);
		sat32 = (v[34:32] != 3'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// configuration
	logic        mode_q;
	logic [23:0] sz_q;
	logic [31:0] view_q;
	logic [CW-1:0] icount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= vrf_pkg::MODE_FIXED;
			sz_q     <= 24'd256;
			view_q   <= '0;
			icount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vrf_pkg::REG_SIZE_MODE:  mode_q   <= cfg_data[0];
				vrf_pkg::REG_FIXED_SIZE: sz_q     <= cfg_data[23:0];
				vrf_pkg::REG_VIEWPORT:   view_q   <= cfg_data;
				vrf_pkg::REG_ITEM_COUNT: icount_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] count_w, count_m1;
	assign count_w  = (icount_q > CW'(vrf_pkg::MAX_ITEMS)) ? CW'(vrf_pkg::MAX_ITEMS) : icount_q;
	assign count_m1 = count_w - CW'(1);

	// latched request
	logic          act_q;
	logic [IW-1:0] idx_q;
	logic [23:0]   isz_q;
	logic [31:0]   scroll_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q    <= in_user;
			idx_q    <= in_data[IW-1:0];
			isz_q    <= in_data[IW+23:IW];
			scroll_q <= in_data[IW+55:IW+24];
		end
	end

	// search, scan and result registers
	logic [CW-1:0] lo_q, hi_q, end_q;
	logic [IW-1:0] start_q;
	logic [31:0]   off_q, tot_q;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid, mid1, end1;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign mid1    = mid + CW'(1);
	assign end1    = end_q + CW'(1);

	// prefix table: entry k+1 lives at address k, entry zero reads as 0
	logic [31:0]   mem [vrf_pkg::MAX_ITEMS];
	logic [CW-1:0] rd_k, rd_km1;
	logic [IW-1:0] rd_addr;
	logic [31:0]   rdata_q, rdata;
	logic          rzero_q;
	logic [34:0]   ld_sum;

	always_comb begin
		case (cmd.rd_sel)
			vrf_pkg::RD_IDX:   rd_k = {1'b0, idx_q};
			vrf_pkg::RD_MID:   rd_k = mid1;
			vrf_pkg::RD_START: rd_k = {1'b0, start_q};
			vrf_pkg::RD_COUNT: rd_k = count_w;
			vrf_pkg::RD_END:   rd_k = end1;
			default:           rd_k = '0;
		endcase
	end

	assign rd_km1  = rd_k - CW'(1);
	assign rd_addr = rd_km1[IW-1:0];
	assign rdata   = rzero_q ? 32'd0 : rdata_q;
	assign ld_sum  = {3'd0, rdata} + {11'd0, isz_q};

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		rzero_q <= (rd_k == '0);
		if (cmd.ld_write) begin
			mem[idx_q] <= sat32(ld_sum);
		end
	end

	// two restoring dividers by the fixed item size, one bit per cycle
	logic [31:0] sq_q, vq_q;
	logic [23:0] sr_q, vr_q;
	logic [vrf_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [24:0] s_t, v_t, s_d, v_d;
	logic        s_ge, v_ge;

	assign s_t  = {sr_q, sq_q[31]};
	assign v_t  = {vr_q, vq_q[31]};
	assign s_d  = s_t - {1'b0, sz_q};
	assign v_d  = v_t - {1'b0, sz_q};
	assign s_ge = s_t >= {1'b0, sz_q};
	assign v_ge = v_t >= {1'b0, sz_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			sq_q      <= scroll_q;
			vq_q      <= view_q;
			sr_q      <= '0;
			vr_q      <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			sq_q      <= {sq_q[30:0], s_ge};
			vq_q      <= {vq_q[30:0], v_ge};
			sr_q      <= s_ge ? s_d[23:0] : s_t[23:0];
			vr_q      <= v_ge ? v_d[23:0] : v_t[23:0];
			div_cnt_q <= div_cnt_q + vrf_pkg::DIV_CNT_W'(1);
		end
	end

	// fixed mode start and end
	logic [IW-1:0] fx_start_n;
	logic [CW+1:0] fx_sum;
	logic [CW-1:0] fx_end_n;

	assign fx_start_n = (sq_q >= {21'd0, count_w}) ? count_m1[IW-1:0] : sq_q[IW-1:0];
	assign fx_sum     = {3'b0, fx_start_n} + {2'b0, vq_q[CW-1:0]} + MARGIN_FIXED;

	always_comb begin
		if (vq_q >= {21'd0, count_w}) begin
			fx_end_n = count_m1;
		end else if (fx_sum >= {2'b0, count_w}) begin
			fx_end_n = count_m1;
		end else begin
			fx_end_n = fx_sum[CW-1:0];
		end
	end

	// variable mode
	logic [32:0]   limit;
	logic [CW:0]   fin_tmp;
	logic [CW-1:0] fin_end;
	logic [34:0]   off_prod, tot_prod;

	assign limit    = {1'b0, scroll_q} + {1'b0, view_q};
	assign fin_tmp  = ({1'b0, end1} < {1'b0, count_w}) ? {1'b0, end1} : {1'b0, end_q};
	assign fin_end  = (fin_tmp >= {1'b0, count_w}) ? count_m1 : fin_tmp[CW-1:0];
	assign off_prod = 35'({start_q} * sz_q);
	assign tot_prod = 35'({count_w} * sz_q);

	always_ff @(posedge clk) begin
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= count_w;
		end else if (cmd.bs_update) begin
			if (rdata <= scroll_q) begin
				lo_q <= mid1;
			end else begin
				hi_q <= mid;
			end
		end

		if (cmd.clear_res) begin
			start_q <= '0;
			end_q   <= '0;
			off_q   <= '0;
			tot_q   <= '0;
		end else if (cmd.fx_start) begin
			start_q <= fx_start_n;
			end_q   <= fx_end_n;
		end else if (cmd.fx_mul) begin
			off_q <= sat32(off_prod);
			tot_q <= sat32(tot_prod);
		end else if (cmd.set_start) begin
			start_q <= (lo_q >= count_w) ? count_m1[IW-1:0] : lo_q[IW-1:0];
			end_q   <= (lo_q >= count_w) ? count_m1 : lo_q;
		end else if (cmd.cap_offset) begin
			off_q <= rdata;
		end else if (cmd.cap_total) begin
			tot_q <= rdata;
		end else if (cmd.scan_update) begin
			end_q <= end1;
		end else if (cmd.finish) begin
			end_q <= fin_end;
		end
	end

	// output register
	logic          m_tvalid_q;
	logic [IW-1:0] o_start_q, o_end_q;
	logic [31:0]   o_off_q, o_tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			o_start_q <= start_q;
			o_end_q   <= end_q[IW-1:0];
			o_off_q   <= off_q;
			o_tot_q   <= tot_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, o_tot_q, o_off_q, o_end_q, o_start_q};

	always_comb begin
		stat.action    = act_q;
		stat.size_mode = mode_q;
		stat.empty     = (count_w == '0);
		stat.div_last  = (div_cnt_q == vrf_pkg::DIV_CNT_W'(vrf_pkg::DIV_STEPS - 1));
		stat.bs_more   = (lo_q < hi_q);
		stat.scan_more = (end_q < count_w);
		stat.scan_hit  = ({1'b0, rdata} < limit);
		stat.out_busy  = m_tvalid_q & ~m_tready;
	end

endmodule

`default_nettype wire

@@ hdl/vrf_ctrl.sv @@
// Controller state machine: sequences loads, fixed-mode division and the
// variable-mode search and scan. Depends on vrf_pkg.
`default_nettype none

module vrf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  vrf_pkg::vrf_stat_t stat,
	output vrf_pkg::vrf_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_LD_WR   = 4'd2;
	localparam logic [3:0] S_DIV     = 4'd3;
	localparam logic [3:0] S_FX_CALC = 4'd4;
	localparam logic [3:0] S_FX_MUL  = 4'd5;
	localparam logic [3:0] S_BS_CHK  = 4'd6;
	localparam logic [3:0] S_BS_CMP  = 4'd7;
	localparam logic [3:0] S_OFF_RD  = 4'd8;
	localparam logic [3:0] S_OFF_CAP = 4'd9;
	localparam logic [3:0] S_TOT_CAP = 4'd10;
	localparam logic [3:0] S_SC_CHK  = 4'd11;
	localparam logic [3:0] S_SC_CMP  = 4'd12;
	localparam logic [3:0] S_FIN     = 4'd13;
	localparam logic [3:0] S_DONE    = 4'd14;

	logic [3:0] state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_n   = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.action == vrf_pkg::ACT_LOAD) begin
					// fetch the preceding prefix entry
					cmd.rd_sel = vrf_pkg::RD_IDX;
					state_n    = S_LD_WR;
				end else if (stat.empty) begin
					cmd.clear_res = 1'b1;
					state_n       = S_DONE;
				end else if (stat.size_mode == vrf_pkg::MODE_FIXED) begin
					cmd.div_init = 1'b1;
					state_n      = S_DIV;
				end else begin
					cmd.bs_init = 1'b1;
					state_n     = S_BS_CHK;
				end
			end
			S_LD_WR: begin
				cmd.ld_write = 1'b1;
				state_n      = S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_n = S_FX_CALC;
				end
			end
			S_FX_CALC: begin
				cmd.fx_start = 1'b1;
				state_n      = S_FX_MUL;
			end
			S_FX_MUL: begin
				cmd.fx_mul = 1'b1;
				state_n    = S_DONE;
			end
			S_BS_CHK: begin
				if (stat.bs_more) begin
					cmd.rd_sel = vrf_pkg::RD_MID;
					state_n    = S_BS_CMP;
				end else begin
					cmd.set_start = 1'b1;
					state_n       = S_OFF_RD;
				end
			end
			S_BS_CMP: begin
				cmd.bs_update = 1'b1;
				state_n       = S_BS_CHK;
			end
			S_OFF_RD: begin
				cmd.rd_sel = vrf_pkg::RD_START;
				state_n    = S_OFF_CAP;
			end
			S_OFF_CAP: begin
				cmd.cap_offset = 1'b1;
				cmd.rd_sel     = vrf_pkg::RD_COUNT;
				state_n        = S_TOT_CAP;
			end
			S_TOT_CAP: begin
				cmd.cap_total = 1'b1;
				state_n       = S_SC_CHK;
			end
			S_SC_CHK: begin
				if (stat.scan_more) begin
					cmd.rd_sel = vrf_pkg::RD_END;
					state_n    = S_SC_CMP;
				end else begin
					state_n = S_FIN;
				end
			end
			S_SC_CMP: begin
				// advance while the item ends before the window end
				if (stat.scan_hit) begin
					cmd.scan_update = 1'b1;
					state_n         = S_SC_CHK;
				end else begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_n    = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.publish = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/visible_range_finder.sv @@
// Top level of the visible range finder: stream ports, configuration port.
// Instantiates vrf_ctrl and vrf_dp; depends on vrf_pkg.
`default_nettype none

// Takes one request at a time: a load (tuser 0) writes one entry of a
// 1024-item prefix table of item ends; a query (tuser 1) returns one result.
// Fixed-size queries run two restoring dividers in parallel, one quotient bit
// per cycle. Variable-size queries run a binary search of at most 11 steps,
// then scan the items across the window; every step waits on the single read
// port of the prefix table. An empty list answers with a cleared result.
// A finished result sits in an output register, so the next request is taken
// while it waits; a further query stalls only until that result is taken.
// Configuration is taken every cycle; write it only while no request is in flight.
module visible_range_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// load_slot[9:0], item_size[33:10], scroll_pos[65:34], zero fill
	input  logic [vrf_pkg::IN_DATA_W-1:0]       s_tdata,
	// action
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// start_index[9:0], end_index[19:10], start_offset[51:20],
	// total_length[83:52], zero fill
	output logic [vrf_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vrf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vrf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	vrf_pkg::vrf_cmd_t  cmd;
	vrf_pkg::vrf_stat_t stat;

	assign cfg_ready = 1'b1;

	vrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vrf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

@@ hdl/vrf_checker.sv @@
// Port-level checker for visible_range_finder, bound to the top level.
// Depends on vrf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vrf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [vrf_pkg::OUT_DATA_W-1:0]    m_tdata
);

	`VRF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`VRF_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`VRF_ASSERT_IMPL(a_range_order, clk, arst_n, m_tvalid, m_tdata[19:10] >= m_tdata[9:0], "end index below start index")
	`VRF_ASSERT_NEXT(a_one_request, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

bind visible_range_finder vrf_checker u_vrf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
